### src/acfp_pkg.sv
// Shared types, constants and the command filter function for the command frame parser.
package acfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned ARG_SLOTS = 16;
  localparam int unsigned CFG_AW    = 4;
  localparam int unsigned CFG_DW    = 32;

  localparam logic [BYTE_W-1:0] GROUP_LO    = 8'hF0;
  localparam logic [BYTE_W-1:0] GROUP_HI    = 8'hFE;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;

  localparam logic [BYTE_W-1:0] DEV_ADDR_RST = 8'd0;
  localparam logic [BYTE_W-1:0] SYNC_RST     = 8'd255;
  localparam logic [BYTE_W-1:0] BCAST_RST    = 8'd239;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_DEV_ADDR = 2'd0,
    REG_SYNC     = 2'd1,
    REG_BCAST    = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_ARGS = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] dev_addr;
    logic [BYTE_W-1:0] sync_code;
    logic [BYTE_W-1:0] bcast_code;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] command;
  } frame_t;

  // A command is taken when it is our address, a matching group code, or broadcast.
  function automatic logic cmd_accepted(input logic [BYTE_W-1:0] c, input cfg_t cfg);
    logic grp;
    grp = (c inside {[GROUP_LO:GROUP_HI]}) &&
          ((c & NIBBLE_MASK) == (cfg.dev_addr >> 4));
    return (c == cfg.dev_addr) || grp || (c == cfg.bcast_code);
  endfunction

endpackage

### src/acfp_ifs.sv
// Valid/ready channel interfaces for received bytes and frame results.
interface acfp_in_if
  import acfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface acfp_out_if
  import acfp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] command_code;
  logic [IDX_W-1:0]  arg_index;
  logic [BYTE_W-1:0] arg_value;
  logic              frame_last;

  modport source (output valid, output command_code, output arg_index,
                  output arg_value, output frame_last, input ready);
  modport sink (input valid, input command_code, input arg_index,
                input arg_value, input frame_last, output ready);
endinterface

### src/addressed_command_frame_parser_core.sv
// Top level of the addressed command frame parser with its configuration registers.
// The byte that completes a frame sets the drain's active flag, which issues the first
// store read; the read register then shows the first result, and results follow one
// per cycle while the sink is ready. Throughput: one received byte per cycle while
// input is open; a completed frame blocks input until its last result is transferred.
// Reset: rst_n is synchronous and active low; it restores the register defaults,
// idles the parser and drops any pending frame. The argument store is not cleared.
module addressed_command_frame_parser_core
  import acfp_pkg::*;
#(
  parameter int unsigned ARG_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  acfp_in_if.sink           in_ch,
  acfp_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Configuration registers. Writes land in the access phase of an APB
  // transfer; the bus never waits.
  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dev_addr: DEV_ADDR_RST, sync_code: SYNC_RST, bcast_code: BCAST_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_DEV_ADDR: cfg_nxt.dev_addr   = cfg_pwdata[BYTE_W-1:0];
        REG_SYNC:     cfg_nxt.sync_code  = cfg_pwdata[BYTE_W-1:0];
        REG_BCAST:    cfg_nxt.bcast_code = cfg_pwdata[BYTE_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEV_ADDR: cfg_prdata = CFG_DW'(cfg_r.dev_addr);
      REG_SYNC:     cfg_prdata = CFG_DW'(cfg_r.sync_code);
      REG_BCAST:    cfg_prdata = CFG_DW'(cfg_r.bcast_code);
      default:      cfg_prdata = '0;
    endcase
  end

  // Input is held off while a completed frame is being read out of the store,
  // which keeps the store and the held command stable during the drain.
  logic              drain_busy;
  logic              in_xfer;
  ram_wr_t           ram_wr;
  frame_t            frame;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              res_valid;
  logic [IDX_W-1:0]  res_idx;
  logic              res_last;

  assign in_ch.ready = !drain_busy;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  acfp_parser #(
    .ARG_COUNT(ARG_COUNT)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .byte_vld(in_xfer),
    .byte_in (in_ch.rx_byte),
    .ram_wr  (ram_wr),
    .frame   (frame)
  );

  // Argument store: one write per argument byte, one read per result.
  acfp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(ARG_SLOTS)
  ) u_arg_ram (
    .clk    (clk),
    .wr_en  (ram_wr.en),
    .wr_addr(ram_wr.addr),
    .wr_data(ram_wr.data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  acfp_drain #(
    .ARG_COUNT(ARG_COUNT)
  ) u_drain (
    .clk      (clk),
    .rst_n    (rst_n),
    .frame    (frame),
    .out_ready(out_ch.ready),
    .out_valid(res_valid),
    .out_idx  (res_idx),
    .out_last (res_last),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .busy     (drain_busy)
  );

  // The held command stays put until the next frame, which cannot start
  // before the drain has finished.
  assign out_ch.valid        = res_valid;
  assign out_ch.command_code = frame.command;
  assign out_ch.arg_index    = res_idx;
  assign out_ch.arg_value    = rd_data;
  assign out_ch.frame_last   = res_last;

  // A result is never shown while new bytes are being taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(out_ch.valid && in_ch.ready))
    else $error("result shown while input is open");

  // Results of one frame follow back to back with rising index.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.frame_last |=>
      out_ch.valid && (out_ch.arg_index == IDX_W'($past(out_ch.arg_index) + 1)))
    else $error("frame results not contiguous");

  // Input reopens right after the last result of a frame is transferred.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.frame_last |=> in_ch.ready)
    else $error("input not reopened after frame");

  // A frame starts only from the byte taken in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    frame.start |-> in_xfer && ram_wr.en)
    else $error("frame start without argument write");

endmodule

### src/acfp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module acfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/acfp_parser.sv
// Byte parser: sync detection, command filtering and argument writes into the store.
module acfp_parser
  import acfp_pkg::*;
#(
  parameter int unsigned ARG_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              byte_vld,
  input  logic [BYTE_W-1:0] byte_in,
  output ram_wr_t           ram_wr,
  output frame_t            frame
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ARG_COUNT - 1);

  phase_t            phase_r, phase_nxt;
  logic [IDX_W-1:0]  fill_r, fill_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic              start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fill_r  <= '0;
      cmd_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    cmd_nxt   = cmd_r;
    start     = 1'b0;
    ram_wr    = '{en: 1'b0, addr: fill_r, data: byte_in};
    if (byte_vld) begin
      if (byte_in == cfg.sync_code) begin
        phase_nxt = PH_CMD;
      end else begin
        case (phase_r)
          PH_CMD: begin
            cmd_nxt   = byte_in;
            fill_nxt  = '0;
            phase_nxt = cmd_accepted(byte_in, cfg) ? PH_ARGS : PH_IDLE;
          end
          PH_ARGS: begin
            ram_wr.en = 1'b1;
            if (fill_r == LAST_IDX) begin
              fill_nxt  = '0;
              start     = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              fill_nxt = fill_r + IDX_W'(1);
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign frame = '{start: start, command: cmd_r};

endmodule

### src/acfp_drain.sv
// Frame drain: reads the stored arguments in order and presents them as results.
module acfp_drain
  import acfp_pkg::*;
#(
  parameter int unsigned ARG_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  frame_t           frame,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_idx,
  output logic             out_last,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  output logic             busy
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ARG_COUNT - 1);

  logic             active_r, active_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r <= out_idx_nxt;
  end

  // The RAM read register doubles as the result payload register, so a read
  // is issued only when the current result is gone or leaves this cycle.
  always_comb begin
    active_nxt    = active_r;
    rd_idx_nxt    = rd_idx_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = active_r && (!out_valid_r || out_ready);
    if (rd_en) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = rd_idx_r;
      if (rd_idx_r == LAST_IDX) begin
        active_nxt = 1'b0;
        rd_idx_nxt = '0;
      end else begin
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
      end
    end
    if (frame.start) begin
      active_nxt = 1'b1;
      rd_idx_nxt = '0;
    end
  end

  assign rd_addr   = rd_idx_r;
  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_last  = (out_idx_r == LAST_IDX);
  assign busy      = active_r || out_valid_r;

endmodule

### tb/addressed_command_frame_parser_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench: random framed byte traffic against a frame predictor and scoreboard.
module addressed_command_frame_parser_core_tb
  import acfp_pkg::*;
();

  // The block is built with full sixteen-byte frames, and the predictor uses the same count.
  localparam int unsigned ARG_COUNT = 16;
  // Quiet cycles after the last result before any register write. This covers the drain's
  // active flag and read register and the store read-out, with some margin.
  localparam int unsigned DRAIN_GAP = ARG_COUNT + 8;
  // Length of the long receiver stall that forces the block to back up into its input.
  localparam int unsigned LONG_HOLD = 200;
  // Cycles without any transfer on either channel before the run is declared hung.
  // The longest correct quiet stretch is the long stall plus a drain pause and the APB writes.
  localparam int unsigned STALL_LIMIT = 4000;
  // Received bytes sent under each register setting.
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned PHASE_COUNT = 6;

  // The opening bytes, all under the reset setting (address 0x00, sync 0xFF, broadcast 0xEF).
  // In order they cover these cases:
  //   - a sync followed by a second sync, so the sync is never taken as a command;
  //   - the unit's own address as the command, then three arguments, then a sync inside the
  //     arguments, which drops the partial frame;
  //   - a rejected command, then a stray byte that arrives while the parser is idle;
  //   - a group code that matches the high nibble of the address, then a full frame whose
  //     arguments run from 0x00 to 0xFE, with single set bits and mixed patterns in between.
  localparam logic [BYTE_W-1:0] OPENING_BYTES [27] = '{
    8'hFF, 8'hFF, 8'h00, 8'h11, 8'h22, 8'h33, 8'hFF, 8'h55, 8'h12, 8'hFF, 8'hF0,
    8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h0F,
    8'hF0, 8'h10, 8'h20, 8'h40, 8'h08, 8'h04, 8'h02, 8'hFE
  };

  typedef struct packed {
    logic [BYTE_W-1:0] command_code;
    logic [IDX_W-1:0]  arg_index;
    logic [BYTE_W-1:0] arg_value;
    logic              frame_last;
  } frame_result_t;

  // This class follows the parser's state from the accepted bytes. It queues the sixteen
  // results of each completed frame and checks every result transfer against the oldest one.
  class frame_scoreboard;
    logic [BYTE_W-1:0] dev_addr;
    logic [BYTE_W-1:0] sync_code;
    logic [BYTE_W-1:0] bcast_code;
    phase_t            phase;
    logic [BYTE_W-1:0] held_command;
    logic [4:0]        arg_fill;
    logic [BYTE_W-1:0] arg_store [ARG_SLOTS];
    frame_result_t     frame_results_due [$];
    int unsigned       errors;
    int unsigned       frames_done;
    int unsigned       results_checked;

    function new();
      dev_addr     = DEV_ADDR_RST;
      sync_code    = SYNC_RST;
      bcast_code   = BCAST_RST;
      phase        = PH_IDLE;
      held_command = '0;
      arg_fill     = '0;
      foreach (arg_store[i]) arg_store[i] = '0;
      errors          = 0;
      frames_done     = 0;
      results_checked = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [BYTE_W-1:0] v);
      case (r)
        REG_DEV_ADDR: dev_addr = v;
        REG_SYNC:     sync_code = v;
        REG_BCAST:    bcast_code = v;
        default:      ;
      endcase
    endfunction

    function bit command_taken(logic [BYTE_W-1:0] c);
      bit group_hit;
      group_hit = (c inside {[GROUP_LO:GROUP_HI]}) && (c[3:0] == dev_addr[7:4]);
      return (c == dev_addr) || group_hit || (c == bcast_code);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      int k;
      // A sync byte restarts the frame from every phase, including the command slot.
      if (b == sync_code) begin
        phase = PH_CMD;
        return;
      end
      case (phase)
        PH_CMD: begin
          held_command = b;
          arg_fill     = '0;
          if (command_taken(b)) phase = PH_ARGS;
          else phase = PH_IDLE;
        end
        PH_ARGS: begin
          arg_store[arg_fill[3:0]] = b;
          arg_fill = arg_fill + 5'd1;
          if (arg_fill >= ARG_COUNT) begin
            for (k = 0; k < ARG_COUNT; k++) begin
              frame_results_due.push_back('{command_code: held_command,
                                            arg_index:    k[IDX_W-1:0],
                                            arg_value:    arg_store[k],
                                            frame_last:   (k == ARG_COUNT - 1)});
            end
            frames_done++;
            phase = PH_IDLE;
          end
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (frame_results_due.size() == 0) begin
        $error("frame result with nothing pending: command_code %h arg_index %0d",
               got.command_code, got.arg_index);
        errors++;
        return;
      end
      want = frame_results_due.pop_front();
      results_checked++;
      if (got.command_code !== want.command_code) begin
        $error("command_code: expected %h, got %h", want.command_code, got.command_code);
        errors++;
      end
      if (got.arg_index !== want.arg_index) begin
        $error("arg_index: expected %0d, got %0d", want.arg_index, got.arg_index);
        errors++;
      end
      if (got.arg_value !== want.arg_value) begin
        $error("arg_value: expected %h, got %h", want.arg_value, got.arg_value);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %b, got %b", want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  acfp_in_if  in_ch ();
  acfp_out_if out_ch ();

  frame_scoreboard sb = new();

  // These counters are used by the stimulus, the receiver, the monitor and the watchdog.
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 8;
  int unsigned reg_writes = 0;
  int unsigned hold_req = 0;
  int unsigned hold_done = 0;
  int unsigned stall_count = 0;

  addressed_command_frame_parser_core #(
    .ARG_COUNT (ARG_COUNT)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The monitor samples at the rising edge, where both channels have been stable since the
  // falling edge. Input transfers are noted before the output is checked. An input transfer
  // cannot show up as a result in the same cycle, so this order costs nothing.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{command_code: out_ch.command_code,
                          arg_index:    out_ch.arg_index,
                          arg_value:    out_ch.arg_value,
                          frame_last:   out_ch.frame_last});
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_count <= 0;
      else stall_count <= stall_count + 1;
    end
  end

  // The watchdog trips only when neither channel has moved for a long time.
  initial begin
    do @(posedge clk); while (stall_count < STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // The receiver runs in stretches of random length. Each stretch is always ready, ready at
  // random, or ready only one cycle in four. A hold request from the stimulus overrides the
  // stretches. The receiver then stays not ready for the whole long stall, counted here.
  initial begin
    int unsigned mode;
    int unsigned stretch;
    mode    = 0;
    stretch = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_done++;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(8, 64);
        end
        stretch--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offers one byte and returns at the falling edge after its transfer. Valid stays high
  // inside a burst and drops only for the random gap that closes a burst.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    in_ch.rx_byte <= b;
    in_ch.valid   <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      // About one burst in five is a long run with no idling at all.
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 80);
      else burst_left = $urandom_range(1, 12);
    end
  endtask

  // Sends one frame: a sync, then a command that is mostly one the unit accepts, then the
  // arguments. A few frames are broken by a sync among the arguments or cut short. Arguments
  // steer clear of the sync value, so that the well-formed frames complete.
  task automatic send_frame();
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] b;
    int unsigned       roll;
    int unsigned       cut;
    int unsigned       k;
    roll = $urandom_range(0, 99);
    cut  = $urandom_range(0, ARG_COUNT - 1);
    case ($urandom_range(0, 5))
      0, 1:    cmd = sb.dev_addr;
      2:       cmd = {4'hF, sb.dev_addr[7:4]};
      3:       cmd = sb.bcast_code;
      4:       cmd = {4'hF, 4'($urandom_range(0, 15))};
      default: cmd = 8'($urandom);
    endcase
    send_byte(sb.sync_code);
    send_byte(cmd);
    for (k = 0; k < ARG_COUNT; k++) begin
      if (roll < 8 && k == cut) begin
        send_byte(sb.sync_code);
        break;
      end
      if (roll >= 8 && roll < 12 && k == cut) break;
      b = 8'($urandom);
      if (b == sb.sync_code) b = ~b;
      send_byte(b);
    end
    // Line noise between frames.
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
  endtask

  // Stops offering bytes until every pending result has been transferred. It then waits out
  // the pipeline, so that the block is idle for a register write.
  task automatic pause_until_drained();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (sb.frame_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Performs an APB write, then reads the same register back with psel held high.
  task automatic write_reg(input reg_idx_t r, input logic [BYTE_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= {{(CFG_DW - BYTE_W){1'b0}}, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(r, v);
    reg_writes++;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[BYTE_W-1:0] !== v) begin
      $error("%s readback: expected %h, got %h", r.name(), v, cfg_prdata[BYTE_W-1:0]);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    logic [BYTE_W-1:0] new_addr;
    logic [BYTE_W-1:0] new_sync;
    logic [BYTE_W-1:0] new_bcast;
    int unsigned       target;
    int unsigned       p;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening, under the reset register values.
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

    // Random frames under several register settings. The first phase keeps the reset values.
    // Phases 1 and 2 push every register to its extremes. Phase 3 puts a high address nibble
    // of 0xF under test, so the code 0xFF lands just past the group range. Phase 5 is random.
    for (p = 0; p < PHASE_COUNT; p++) begin
      if (p > 0) begin
        case (p)
          1: begin new_addr = 8'hFF; new_sync = 8'h00; new_bcast = 8'hFF; end
          2: begin new_addr = 8'h00; new_sync = 8'hFF; new_bcast = 8'h00; end
          3: begin new_addr = 8'hF3; new_sync = 8'h7E; new_bcast = 8'h80; end
          4: begin new_addr = 8'h5A; new_sync = 8'hA5; new_bcast = 8'hEF; end
          default: begin
            new_addr  = 8'($urandom);
            new_sync  = 8'($urandom);
            new_bcast = 8'($urandom);
          end
        endcase
        pause_until_drained();
        write_reg(REG_DEV_ADDR, new_addr);
        write_reg(REG_SYNC, new_sync);
        write_reg(REG_BCAST, new_bcast);
      end
      // In phase 1 the receiver stalls for a long time while frames keep arriving. The
      // pending frame then blocks the input side.
      if (p == 1) hold_req++;
      target = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < target) begin
        send_frame();
        // In phase 3 the sender pauses midway, after each frame ending in this window, until drained.
        if (p == 3 && bytes_sent >= target - PHASE_ITEMS / 2 && bytes_sent < target - 12) begin
          pause_until_drained();
        end
      end
    end

    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (sb.frame_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);

    $display("Covered %0d received bytes, %0d register settings and %0d register writes.",
             bytes_sent, PHASE_COUNT, reg_writes);
    $display("Checked %0d completed frames and %0d argument transfers.",
             sb.frames_done, sb.results_checked);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
